// File: rtl/core/gses_pkg.sv
package gses_pkg;

  // saturating tally width
  localparam int unsigned CNT_W = 17;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned FIRST_W = 5;
  localparam int unsigned END_W   = 6;
  localparam int unsigned CAND_W  = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEST    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [END_W-1:0] END_ROW_RESET = 6'd32;

  // apb word index of each register
  localparam logic REG_FIRST_ROW = 1'b0;
  localparam logic REG_END_ROW   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic load;
    logic restart;
    logic start;
    logic advance;
    logic fail;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic empty_range;
    logic mismatch;
    logic last_row;
  } dp_status_t;

endpackage

// File: rtl/core/gses_ctrl.sv
module gses_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [gses_pkg::CMD_W-1:0]    command_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output gses_pkg::dp_cmd_t             dp_cmd_o,
  input  gses_pkg::dp_status_t          dp_status_i
);

  gses_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire;
  logic             slot_free;

  assign in_ready_o  = (state_q == gses_pkg::ST_IDLE);
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign slot_free   = ~out_valid_q | out_ready_i;

  always_comb begin
    state_d  = state_q;
    dp_cmd_o = '0;
    unique case (state_q)
      gses_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (command_i)
            gses_pkg::CMD_LOAD:    dp_cmd_o.load = 1'b1;
            gses_pkg::CMD_RESTART: dp_cmd_o.restart = 1'b1;
            gses_pkg::CMD_TEST: begin
              dp_cmd_o.start = 1'b1;
              state_d = dp_status_i.empty_range ? gses_pkg::ST_DONE : gses_pkg::ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      gses_pkg::ST_SCAN: begin
        // row data for the current pointer is valid here
        if (dp_status_i.mismatch) begin
          dp_cmd_o.fail = 1'b1;
          state_d = gses_pkg::ST_DONE;
        end else if (dp_status_i.last_row) begin
          state_d = gses_pkg::ST_DONE;
        end else begin
          dp_cmd_o.advance = 1'b1;
        end
      end
      gses_pkg::ST_DONE: begin
        if (slot_free) begin
          dp_cmd_o.commit = 1'b1;
          state_d = gses_pkg::ST_IDLE;
        end
      end
      default: state_d = gses_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (dp_cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gses_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/gses_dp.sv
module gses_dp #(
  parameter int unsigned NUM_VARS = 16,
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gses_pkg::dp_cmd_t                dp_cmd_i,
  output gses_pkg::dp_status_t             dp_status_o,
  input  logic [gses_pkg::IDX_W-1:0]       row_index_i,
  input  logic [gses_pkg::COEF_W-1:0]      row_coefficients_i,
  input  logic                             row_rhs_i,
  input  logic [gses_pkg::FIRST_W-1:0]     first_row_i,
  input  logic [gses_pkg::END_W-1:0]       end_row_i,
  output logic [gses_pkg::CAND_W-1:0]      candidate_o,
  output logic                             satisfied_o,
  output logic [gses_pkg::CNT_W-1:0]       solution_count_o,
  output logic [gses_pkg::CNT_W-1:0]       failure_count_o,
  output logic                             sweep_last_o
);

  localparam int unsigned ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CLOG_R = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMP_W  = (CLOG_R > gses_pkg::END_W) ? CLOG_R : gses_pkg::END_W;
  localparam int unsigned CNT_W  = gses_pkg::CNT_W;
  localparam int unsigned COEF_W = gses_pkg::COEF_W;

  logic [COEF_W-1:0] coef_mem [MAX_ROWS];
  logic              rhs_mem  [MAX_ROWS];
  logic [COEF_W-1:0] coef_q;
  logic              rhs_q;

  logic [NUM_VARS-1:0] cand_q, cand_d;
  logic [CNT_W-1:0]    sol_q, sol_d, fail_q, fail_d;
  logic [CMP_W-1:0]    ptr_q, ptr_d;
  logic                ok_q, ok_d;

  logic [gses_pkg::CAND_W-1:0] out_cand_q;
  logic                        out_sat_q, out_last_q;
  logic [CNT_W-1:0]            out_sol_q, out_fail_q;

  logic [CMP_W-1:0]  end_ext, last_row, first_ext, ptr_inc;
  logic [ROW_W-1:0]  rd_addr, wr_addr;
  logic              rd_en, wr_en;
  logic [COEF_W-1:0] cand_view;

  // low bits of the candidate as seen by a coefficient row
  for (genvar k = 0; k < COEF_W; k++) begin : g_view
    if (k < NUM_VARS) begin : g_bit
      assign cand_view[k] = cand_q[k];
    end else begin : g_zero
      assign cand_view[k] = 1'b0;
    end
  end

  assign end_ext   = CMP_W'(end_row_i);
  assign last_row  = (end_ext > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : end_ext;
  assign first_ext = CMP_W'(first_row_i);
  assign ptr_inc   = ptr_q + CMP_W'(1);

  assign dp_status_o.empty_range = (first_ext >= last_row);
  assign dp_status_o.mismatch    = (^(coef_q & cand_view)) ^ rhs_q;
  assign dp_status_o.last_row    = (ptr_inc >= last_row);

  assign wr_en   = dp_cmd_i.load & (CMP_W'(row_index_i) < CMP_W'(MAX_ROWS));
  assign wr_addr = ROW_W'(row_index_i);
  assign rd_en   = dp_cmd_i.start | dp_cmd_i.advance;
  assign rd_addr = dp_cmd_i.start ? ROW_W'(first_ext) : ROW_W'(ptr_inc);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      coef_mem[wr_addr] <= row_coefficients_i;
      rhs_mem[wr_addr]  <= row_rhs_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      coef_q <= coef_mem[rd_addr];
      rhs_q  <= rhs_mem[rd_addr];
    end
  end

  always_comb begin
    cand_d = cand_q;
    sol_d  = sol_q;
    fail_d = fail_q;
    ptr_d  = ptr_q;
    ok_d   = ok_q;
    if (dp_cmd_i.restart) begin
      cand_d = '0;
      sol_d  = '0;
      fail_d = '0;
    end
    if (dp_cmd_i.start) begin
      cand_d = cand_q + NUM_VARS'(1);
      ptr_d  = first_ext;
      ok_d   = 1'b1;
    end
    if (dp_cmd_i.advance) begin
      ptr_d = ptr_inc;
    end
    if (dp_cmd_i.fail) begin
      ok_d = 1'b0;
    end
    if (dp_cmd_i.commit) begin
      if (ok_q) begin
        sol_d = (sol_q == '1) ? sol_q : sol_q + CNT_W'(1);
      end else begin
        fail_d = (fail_q == '1) ? fail_q : fail_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      sol_q  <= '0;
      fail_q <= '0;
    end else begin
      cand_q <= cand_d;
      sol_q  <= sol_d;
      fail_q <= fail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    ok_q  <= ok_d;
    if (dp_cmd_i.commit) begin
      out_cand_q <= cand_view;
      out_sat_q  <= ok_q;
      out_sol_q  <= sol_d;
      out_fail_q <= fail_d;
      out_last_q <= (cand_q == '0);
    end
  end

  assign candidate_o      = out_cand_q;
  assign satisfied_o      = out_sat_q;
  assign solution_count_o = out_sol_q;
  assign failure_count_o  = out_fail_q;
  assign sweep_last_o     = out_last_q;

endmodule

// File: rtl/core/gf2_exhaustive_solution_search_core.sv
// Brute-force GF(2) solver: load rows (command 0) into a table, restart (command 2) to clear
// the candidate and tallies, and each test (command 1) bumps the candidate and checks rows
// first_row .. end_row-1 in order (end_row capped at MAX_ROWS), stopping at the first row whose
// parity disagrees with its right-hand bit; only test commands produce an output transaction.
// The equation table has a single read port and is scanned one row per cycle. One item is
// processed at a time, but a new item is taken while a finished result waits in the output
// register.
// Configure first_row (addr 0) and end_row (addr 4) over apb only while the block is idle.
module gf2_exhaustive_solution_search_core #(
  parameter int unsigned NUM_VARS = 16,
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [gses_pkg::CMD_W-1:0]       command_i,
  input  logic [gses_pkg::IDX_W-1:0]       row_index_i,
  input  logic [gses_pkg::COEF_W-1:0]      row_coefficients_i,
  input  logic                             row_rhs_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [gses_pkg::CAND_W-1:0]      candidate_o,
  output logic                             satisfied_o,
  output logic [gses_pkg::CNT_W-1:0]       solution_count_o,
  output logic [gses_pkg::CNT_W-1:0]       failure_count_o,
  output logic                             sweep_last_o
);

  logic [gses_pkg::FIRST_W-1:0] first_row_q;
  logic [gses_pkg::END_W-1:0]   end_row_q;
  logic                         cfg_write;

  gses_pkg::dp_cmd_t    dp_cmd;
  gses_pkg::dp_status_t dp_status;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_row_q <= '0;
      end_row_q   <= gses_pkg::END_ROW_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        gses_pkg::REG_FIRST_ROW: first_row_q <= pwdata[gses_pkg::FIRST_W-1:0];
        gses_pkg::REG_END_ROW:   end_row_q   <= pwdata[gses_pkg::END_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      gses_pkg::REG_FIRST_ROW: prdata = 32'(first_row_q);
      gses_pkg::REG_END_ROW:   prdata = 32'(end_row_q);
      default:                 prdata = '0;
    endcase
  end

  gses_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .dp_cmd_o    (dp_cmd),
    .dp_status_i (dp_status)
  );

  gses_dp #(
    .NUM_VARS (NUM_VARS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .dp_cmd_i           (dp_cmd),
    .dp_status_o        (dp_status),
    .row_index_i        (row_index_i),
    .row_coefficients_i (row_coefficients_i),
    .row_rhs_i          (row_rhs_i),
    .first_row_i        (first_row_q),
    .end_row_i          (end_row_q),
    .candidate_o        (candidate_o),
    .satisfied_o        (satisfied_o),
    .solution_count_o   (solution_count_o),
    .failure_count_o    (failure_count_o),
    .sweep_last_o       (sweep_last_o)
  );

endmodule
